@@ hdl/ktsg_pkg.sv @@
// Shared types and constants of the k-nomial tree schedule generator.
package ktsg_pkg;

    // Field and register widths.
    localparam int RANK_W     = 6;
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int KIND_W     = 3;
    localparam int LVL_W      = 3;
    localparam int OFF_W      = 13;
    localparam int TOTAL_W    = 10;

    // Largest group and longest step list.
    localparam int MAX_RANKS    = 64;
    localparam int RESULT_LIMIT = 64;
    localparam int LVL_MAX      = 7;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TREE_RADIX = 1'b1;

    // Reset values of the registers.
    localparam logic [CFG_W-1:0] GROUP_SIZE_RST = 7'd1;
    localparam logic [CFG_W-1:0] TREE_RADIX_RST = 7'd2;

    // Collective kinds on the request channel.
    localparam logic ACT_BCAST  = 1'b0;
    localparam logic ACT_REDUCE = 1'b1;

    // Step codes.
    typedef enum logic [KIND_W-1:0] {
        KIND_NOP     = 3'd0,
        KIND_RECV    = 3'd1,
        KIND_SEND    = 3'd2,
        KIND_RRECV   = 3'd3,
        KIND_RSEND   = 3'd4,
        KIND_INVALID = 3'd5
    } t_step_kind;

    // One step on its way to the output.
    typedef struct packed {
        t_step_kind        kind;
        logic [RANK_W-1:0] peer;
        logic              grp;
    } t_step;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_MUL,
        S_MOD,
        S_PREP,
        S_HEAD,
        S_LEVEL,
        S_DIGIT,
        S_TAIL,
        S_FLUSH
    } t_state;

endpackage

@@ hdl/knomial_tree_schedule_generator_unit.sv @@
// Top level of the k-nomial tree schedule generator: sequencer, shared datapath, output stages.

// A request (collective kind, rank, root) is taken only while the unit is idle and produces that
// rank's broadcast or reduce steps in tree order, one step per output transfer, the last one
// flagged; a bad request yields a single invalid step instead. A request is accepted, then set
// up; then, for each tree level and once more for the test that ends the count, a multiply step
// runs and the shared subtract-compare unit forms the remainder by repeated subtraction (the
// closing test skips it once the span has reached the group size); then comes a preparation
// step, the emitter with a level-start state before each level, and a flush step. The emitter
// walks one digit, a step or a skipped no-op, per cycle while the step channel has room; a
// skipped no-op does not wait for it. The remainder loop takes the front part of a request, the
// emitter the rest.
// One step is held back in a lookahead register so that the last-step flag is known; steps leave
// through an output register, so a stalled consumer only pauses the emitter.
module knomial_tree_schedule_generator_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration writes.
    input  logic                           i_cfg_we,
    input  logic [ktsg_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ktsg_pkg::CFG_W-1:0]     i_cfg_data,
    // Request channel.
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_action,
    input  logic [ktsg_pkg::RANK_W-1:0]    i_my_rank,
    input  logic [ktsg_pkg::RANK_W-1:0]    i_root_rank,
    // Step channel.
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ktsg_pkg::KIND_W-1:0]    o_step_kind,
    output logic [ktsg_pkg::RANK_W-1:0]    o_peer_rank,
    output logic                           o_concurrent_group,
    output logic                           o_last_step
);
    import ktsg_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0]  r_group_size;
    logic [CFG_W-1:0]  r_tree_radix;

    // Sequencer and request registers.
    t_state            r_state, n_state;
    logic              r_action;
    logic [RANK_W-1:0] r_rank;
    logic [RANK_W-1:0] r_root;

    // Tree shape registers.
    logic [RANK_W-1:0] r_rel;
    logic [LVL_W-1:0]  r_h;
    logic [OFF_W-1:0]  r_p;
    logic [OFF_W-1:0]  r_m;
    logic [RANK_W-1:0] r_rem;
    logic [RANK_W-1:0] r_parent;
    logic [RANK_W-1:0] r_par_peer;
    logic              r_skip;

    // Emitter registers.
    logic [LVL_W-1:0]  r_lvl;
    logic [CFG_W-1:0]  r_j;
    logic [OFF_W-1:0]  r_off;
    logic [RANK_W-1:0] r_lvl_pw;

    // Level spans, one entry per tree level.
    logic [RANK_W-1:0] r_pw [0:LVL_MAX];
    logic              pw_we;
    logic [LVL_W-1:0]  pw_waddr;
    logic [RANK_W-1:0] pw_wdata;

    // Lookahead and output stages.
    t_step             r_pend;
    logic              r_pend_v;
    t_step             r_out;
    logic              r_out_last;
    logic              r_out_v;

    // Combinational control.
    logic              accept;
    logic              out_free;
    logic              can_push;
    logic              push;
    logic              pend_adv;
    t_step             new_step;
    logic              req_bad;
    logic [CFG_W-1:0]  rel_calc;
    logic [CFG_W-1:0]  par_sum;
    logic [RANK_W-1:0] par_calc;
    logic [TOTAL_W-1:0] total;
    logic              mul_stop;
    logic              mod_sub;
    logic [OFF_W:0]    child;
    logic              is_nop;
    logic [OFF_W:0]    peer_sum;
    logic [OFF_W:0]    peer_red;
    logic              digit_go;
    logic              last_digit;

    // Handshake helpers.
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_v || i_ready;
    assign can_push = !r_pend_v || out_free;

    // Request checks and relative rank.
    assign req_bad = (r_group_size == '0) || (r_group_size > CFG_W'(MAX_RANKS))
                   || (r_tree_radix < CFG_W'(2))
                   || ({1'b0, r_rank} >= r_group_size) || ({1'b0, r_root} >= r_group_size);
    assign rel_calc = (r_rank >= r_root) ? ({1'b0, r_rank} - {1'b0, r_root})
                                         : ({1'b0, r_rank} + r_group_size - {1'b0, r_root});

    // Absolute parent rank, one conditional subtract for the wrap.
    assign par_sum  = {1'b0, r_root} + {1'b0, r_parent};
    assign par_calc = (par_sum >= r_group_size) ? RANK_W'(par_sum - r_group_size)
                                                : RANK_W'(par_sum);

    // Full step count including no-ops.
    assign total = TOTAL_W'(r_rel != '0) + TOTAL_W'(r_h) * TOTAL_W'(r_tree_radix - CFG_W'(1));

    // Height loop: stop once the level span reaches the group or the height its maximum, else test divisibility.
    assign mul_stop = (r_p >= OFF_W'(r_group_size)) || (r_h == LVL_W'(LVL_MAX));
    assign mod_sub  = OFF_W'(r_rem) >= r_m;

    // Child and peer of the current digit.
    assign child      = (OFF_W + 1)'(r_rel) + (OFF_W + 1)'(r_off);
    assign is_nop     = child >= (OFF_W + 1)'(r_group_size);
    assign peer_sum   = (OFF_W + 1)'(r_rank) + (OFF_W + 1)'(r_off);
    assign peer_red   = (peer_sum >= (OFF_W + 1)'(r_group_size))
                      ? (peer_sum - (OFF_W + 1)'(r_group_size)) : peer_sum;
    assign digit_go   = (is_nop && r_skip) || can_push;
    assign last_digit = r_j == (r_tree_radix - CFG_W'(1));

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = req_bad ? S_FLUSH : S_MUL;
            end
            S_MUL: begin
                n_state = mul_stop ? S_PREP : S_MOD;
            end
            S_MOD: begin
                if (!mod_sub) n_state = (r_rem == '0) ? S_MUL : S_PREP;
            end
            S_PREP: begin
                if (!r_action) begin
                    if (r_rel != '0)     n_state = S_HEAD;
                    else if (r_h == '0)  n_state = S_FLUSH;
                    else                 n_state = S_LEVEL;
                end else begin
                    if (r_h != '0)       n_state = S_LEVEL;
                    else if (r_rel != '0) n_state = S_TAIL;
                    else                 n_state = S_FLUSH;
                end
            end
            S_HEAD: begin
                if (can_push) n_state = (r_h == '0) ? S_FLUSH : S_LEVEL;
            end
            S_LEVEL: begin
                n_state = S_DIGIT;
            end
            S_DIGIT: begin
                if (digit_go && last_digit) begin
                    if (!r_action)
                        n_state = (r_lvl == '0) ? S_FLUSH : S_LEVEL;
                    else if (r_lvl != r_h - LVL_W'(1))
                        n_state = S_LEVEL;
                    else
                        n_state = (r_rel != '0) ? S_TAIL : S_FLUSH;
                end
            end
            S_TAIL: begin
                if (can_push) n_state = S_FLUSH;
            end
            S_FLUSH: begin
                if (!r_pend_v || out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output and step-generation logic of the sequencer.
    always_comb begin
        o_ready  = 1'b0;
        push     = 1'b0;
        new_step = '{kind: KIND_NOP, peer: '0, grp: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
            end
            S_SETUP: begin
                push     = req_bad;
                new_step = '{kind: KIND_INVALID, peer: '0, grp: 1'b0};
            end
            S_HEAD: begin
                push     = can_push;
                new_step = '{kind: KIND_RECV, peer: r_par_peer, grp: 1'b0};
            end
            S_DIGIT: begin
                push = !(is_nop && r_skip) && can_push;
                if (is_nop)
                    new_step = '{kind: KIND_NOP, peer: '0, grp: !r_action};
                else
                    new_step = '{kind: r_action ? KIND_RRECV : KIND_SEND,
                                 peer: RANK_W'(peer_red), grp: !r_action};
            end
            S_TAIL: begin
                push     = can_push;
                new_step = '{kind: KIND_RSEND, peer: r_par_peer, grp: 1'b0};
            end
            S_MUL, S_MOD, S_PREP, S_LEVEL, S_FLUSH: begin
                push = 1'b0;
            end
            default: push = 1'b0;
        endcase
    end

    // The held step moves on only when a later step arrives or the request ends.
    assign pend_adv = r_pend_v && out_free && (push || (r_state == S_FLUSH));

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_v     <= 1'b0;
            r_out_v      <= 1'b0;
            r_group_size <= GROUP_SIZE_RST;
            r_tree_radix <= TREE_RADIX_RST;
        end else begin
            r_state <= n_state;
            if (push)          r_pend_v <= 1'b1;
            else if (pend_adv) r_pend_v <= 1'b0;
            if (pend_adv)      r_out_v  <= 1'b1;
            else if (i_ready)  r_out_v  <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GROUP_SIZE: r_group_size <= i_cfg_data;
                    CFG_TREE_RADIX: r_tree_radix <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Step stages.
    always_ff @(posedge i_clk) begin
        if (push) r_pend <= new_step;
        if (pend_adv) begin
            r_out      <= r_pend;
            r_out_last <= r_state == S_FLUSH;
        end
    end

    // Level span writes: the root level at setup, each new level as the height grows.
    always_comb begin
        pw_we    = 1'b0;
        pw_waddr = '0;
        pw_wdata = RANK_W'(1);
        if (r_state == S_SETUP) begin
            pw_we = 1'b1;
        end else if ((r_state == S_MOD) && !mod_sub && (r_rem == '0)) begin
            pw_we    = 1'b1;
            pw_waddr = r_h + LVL_W'(1);
            pw_wdata = RANK_W'(r_m);
        end
    end

    // Level span memory, read when a level starts.
    always_ff @(posedge i_clk) begin
        if (pw_we) r_pw[pw_waddr] <= pw_wdata;
        if (r_state == S_LEVEL) begin
            r_off    <= OFF_W'(r_pw[r_lvl]);
            r_lvl_pw <= r_pw[r_lvl];
        end else if ((r_state == S_DIGIT) && digit_go) begin
            r_off <= r_off + OFF_W'(r_lvl_pw);
        end
    end

    // Shared datapath: multiply, remainder by repeated subtraction, digit walk.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_action <= i_action;
                    r_rank   <= i_my_rank;
                    r_root   <= i_root_rank;
                end
            end
            S_SETUP: begin
                r_rel <= RANK_W'(rel_calc);
                r_p   <= OFF_W'(1);
                r_h   <= '0;
            end
            S_MUL: begin
                if (mul_stop) begin
                    r_parent <= '0;
                end else begin
                    r_m   <= OFF_W'(r_p[RANK_W-1:0] * r_tree_radix);
                    r_rem <= r_rel;
                end
            end
            S_MOD: begin
                if (mod_sub) begin
                    r_rem <= r_rem - RANK_W'(r_m);
                end else if (r_rem == '0) begin
                    r_h <= r_h + LVL_W'(1);
                    r_p <= r_m;
                end else begin
                    r_parent <= r_rel - r_rem;
                end
            end
            S_PREP: begin
                r_par_peer <= par_calc;
                r_skip     <= total > TOTAL_W'(RESULT_LIMIT);
                r_lvl      <= r_action ? '0 : (r_h - LVL_W'(1));
            end
            S_LEVEL: begin
                r_j <= CFG_W'(1);
            end
            S_DIGIT: begin
                if (digit_go) begin
                    r_j <= r_j + CFG_W'(1);
                    if (last_digit)
                        r_lvl <= r_action ? (r_lvl + LVL_W'(1)) : (r_lvl - LVL_W'(1));
                end
            end
            S_HEAD, S_TAIL, S_FLUSH: ;
            default: ;
        endcase
    end

    // Port drive.
    assign o_valid            = r_out_v;
    assign o_step_kind        = r_out.kind;
    assign o_peer_rank        = r_out.peer;
    assign o_concurrent_group = r_out.grp;
    assign o_last_step        = r_out_last;

    // A new request starts only with the lookahead stage empty.
    a_idle_pend_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("lookahead step left behind at request start");

    // A step is never pushed over one that has not moved on.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!r_pend_v || pend_adv))
        else $error("held step overwritten");

    // No-op steps carry no peer.
    a_nop_peer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend_v && (r_pend.kind == KIND_NOP)) |-> (r_pend.peer == '0))
        else $error("no-op step with a peer");

    // An invalid request gives exactly one flagged step.
    a_invalid_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && (r_out.kind == KIND_INVALID)) |-> (r_out_last && !r_out.grp))
        else $error("invalid step not final");

    // The digit counter stays within the radix while walking a level.
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT) |-> ((r_j != '0) && (r_j < r_tree_radix)))
        else $error("digit out of range");

endmodule
